// ===== rtl/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and defaults for the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIG     = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_TOO_LARGE   = 3'd4,
    ST_BAD_OFFSET  = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_PAD    = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        image_done;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/bmp_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// Streaming decoder for uncompressed 24/32-bit BMP files, one byte per item.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | data_byte, start_of_file, end_of_file
//  out     | out_valid / out_ready| pixel_valid, red, green, blue, column, row,
//          |                      | image_done, status
//
//  One byte per cycle while the out port takes results. A byte is held in the
//  input register after acceptance, parsed from it, and its result, if any, is
//  held in the result register; each byte's parser state update is combinational.
//  Synchronous reset puts the parser in idle; bytes are ignored until one
//  carries start_of_file.
//  A stalled out port holds its result; the input register takes one more
//  byte meanwhile, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder #(
  parameter int MAX_WIDTH  = bmpd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpd_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pixel_valid,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic        image_done,
  output logic [2:0]  status
);
  import bmpd_pkg::*;

  in_item_t in_item;
  in_item_t item;
  result_t  res;
  result_t  result;
  logic     full;
  logic     take;
  logic     res_valid;

  assign in_item.data_byte     = data_byte;
  assign in_item.start_of_file = start_of_file;
  assign in_item.end_of_file   = end_of_file;

  // Advance the held byte whenever the result register can take its result.
  assign take = full && (!out_valid || out_ready);

  bmpd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .full     (full),
    .item     (item)
  );

  bmpd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  bmpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign pixel_valid = result.pixel_valid;
  assign red         = result.red;
  assign green       = result.green;
  assign blue        = result.blue;
  assign column      = result.column;
  assign row         = result.row;
  assign image_done  = result.image_done;
  assign status      = result.status;

endmodule

// ===== rtl/bmpd_in_reg.sv =====
// ----------------------------------------------------------------------------
// bmpd_in_reg
// Input register: holds one byte item until the parser consumes it.
// ----------------------------------------------------------------------------
module bmpd_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmpd_pkg::in_item_t in_item,
  input  logic               take,
  output logic               full,
  output bmpd_pkg::in_item_t item
);
  import bmpd_pkg::*;

  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/bmpd_core.sv =====
// ----------------------------------------------------------------------------
// bmpd_core
// Parser state and per-byte logic: header capture and checks, offset skip,
// pixel assembly, row padding and row flip.
// ----------------------------------------------------------------------------
module bmpd_core #(
  parameter int MAX_WIDTH  = bmpd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpd_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bmpd_pkg::in_item_t item,
  output logic               res_valid,
  output bmpd_pkg::result_t  res
);
  import bmpd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

  localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
  localparam logic [31:0] HDR_BYTES   = 32'd54;
  localparam logic [5:0]  POS_SIG_END = 6'd13;
  localparam logic [5:0]  POS_HDR_END = 6'd53;
  localparam logic [15:0] BPP_24      = 16'd24;
  localparam logic [15:0] BPP_32      = 16'd32;

  phase_t             phase, phase_next;
  logic [31:0]        byte_position, byte_position_next;
  logic [15:0]        signature_word, signature_word_next;
  logic [31:0]        data_offset, data_offset_next;
  logic [31:0]        image_width, image_width_next;
  logic [31:0]        image_height, image_height_next;
  logic [15:0]        bits_per_pixel, bits_per_pixel_next;
  logic [31:0]        compression_code, compression_code_next;
  logic [ROW_W-1:0]   height_mag, height_mag_next;
  logic [COL_W-1:0]   column_count, column_count_next;
  logic [ROW_W-1:0]   row_count, row_count_next;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next;
  logic [1:0]         row_byte_phase, row_byte_phase_next;
  logic [7:0]         held_blue, held_blue_next;
  logic [7:0]         held_green, held_green_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_position  <= '0;
      column_count   <= '0;
      row_count      <= '0;
      byte_in_pixel  <= '0;
      row_byte_phase <= '0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      byte_in_pixel  <= byte_in_pixel_next;
      row_byte_phase <= row_byte_phase_next;
    end
  end

  // Header fields are cleared on every start of file before use.
  always_ff @(posedge clk) begin
    signature_word   <= signature_word_next;
    data_offset      <= data_offset_next;
    image_width      <= image_width_next;
    image_height     <= image_height_next;
    bits_per_pixel   <= bits_per_pixel_next;
    compression_code <= compression_code_next;
    height_mag       <= height_mag_next;
    held_blue        <= held_blue_next;
    held_green       <= held_green_next;
  end

  always_comb begin
    phase_t            ph;
    logic [7:0]        b;
    logic [5:0]        p;
    logic              ignored;
    logic              pix;
    logic              last;
    status_t           err;
    logic [31:0]       hm32;
    logic [1:0]        lastbyte;
    logic [COL_W-1:0]  col_inc;
    logic [COL_W-1:0]  width_n;
    logic [ROW_W-1:0]  row_inc;
    logic [ROW_W-1:0]  row_idx;
    logic              end_row;
    logic [31:0]       col_wide;
    logic [31:0]       row_wide;

    phase_next            = phase;
    byte_position_next    = byte_position;
    signature_word_next   = signature_word;
    data_offset_next      = data_offset;
    image_width_next      = image_width;
    image_height_next     = image_height;
    bits_per_pixel_next   = bits_per_pixel;
    compression_code_next = compression_code;
    height_mag_next       = height_mag;
    column_count_next     = column_count;
    row_count_next        = row_count;
    byte_in_pixel_next    = byte_in_pixel;
    row_byte_phase_next   = row_byte_phase;
    held_blue_next        = held_blue;
    held_green_next       = held_green;

    b        = item.data_byte;
    ph       = phase;
    p        = '0;
    ignored  = 1'b0;
    pix      = 1'b0;
    last     = 1'b0;
    err      = ST_OK;
    hm32     = '0;
    lastbyte = (bits_per_pixel == BPP_32) ? 2'd3 : 2'd2;
    col_inc  = column_count + COL_W'(1);
    width_n  = image_width[COL_W-1:0];
    row_inc  = row_count + ROW_W'(1);
    row_idx  = row_count;
    end_row  = 1'b0;
    col_wide = '0;
    row_wide = '0;
    res_valid = 1'b0;
    res       = '0;

    if (step) begin
      // Start of file restarts the parse from header byte 0.
      if (item.start_of_file) begin
        ph                    = PH_HEADER;
        byte_position_next    = '0;
        signature_word_next   = '0;
        data_offset_next      = '0;
        image_width_next      = '0;
        image_height_next     = '0;
        bits_per_pixel_next   = '0;
        compression_code_next = '0;
        column_count_next     = '0;
        row_count_next        = '0;
        byte_in_pixel_next    = '0;
        row_byte_phase_next   = '0;
        held_blue_next        = '0;
        held_green_next       = '0;
        col_inc               = COL_W'(1);
        row_inc               = ROW_W'(1);
      end
      phase_next = ph;

      unique case (ph)
        PH_HEADER: begin
          p = byte_position_next[5:0];
          if (p < 6'd2) begin
            signature_word_next[8*p[0] +: 8] = b;
          end else if (p >= 6'd10 && p <= 6'd13) begin
            data_offset_next[8*(2'(p - 6'd10)) +: 8] = b;
          end else if (p >= 6'd18 && p <= 6'd21) begin
            image_width_next[8*(2'(p - 6'd18)) +: 8] = b;
          end else if (p >= 6'd22 && p <= 6'd25) begin
            image_height_next[8*(2'(p - 6'd22)) +: 8] = b;
          end else if (p >= 6'd28 && p <= 6'd29) begin
            bits_per_pixel_next[8*p[0] +: 8] = b;
          end else if (p >= 6'd30 && p <= 6'd33) begin
            compression_code_next[8*(2'(p - 6'd30)) +: 8] = b;
          end

          hm32 = image_height_next[31] ? (~image_height_next + 32'd1) : image_height_next;
          if (p == POS_SIG_END && signature_word_next != BMP_MAGIC) begin
            err = ST_BAD_SIG;
          end else if (p == POS_HDR_END) begin
            priority if (compression_code_next != '0 ||
                         (bits_per_pixel_next != BPP_24 && bits_per_pixel_next != BPP_32)) begin
              err = ST_UNSUPPORTED;
            end else if (image_width_next == '0 || image_width_next[31] ||
                         image_height_next == '0) begin
              err = ST_BAD_SIZE;
            end else if (image_width_next > 32'(MAX_WIDTH) || hm32 > 32'(MAX_HEIGHT)) begin
              err = ST_TOO_LARGE;
            end else if (data_offset_next < HDR_BYTES) begin
              err = ST_BAD_OFFSET;
            end else begin
              height_mag_next = hm32[ROW_W-1:0];
              phase_next = (data_offset_next == HDR_BYTES) ? PH_PIXELS : PH_SKIP;
            end
          end
        end

        PH_SKIP: begin
          if (byte_position + 32'd1 == data_offset) begin
            phase_next = PH_PIXELS;
          end
        end

        PH_PIXELS: begin
          unique case (byte_in_pixel)
            2'd0: held_blue_next = b;
            2'd1: held_green_next = b;
            2'd2: begin
              pix  = 1'b1;
              last = (col_inc == width_n) && (row_inc == height_mag);
              // Bottom-up file: flip the stored row index.
              row_idx = image_height[31] ? row_count
                                         : (height_mag - ROW_W'(1) - row_count);
            end
            default: ; // alpha byte: drop
          endcase
          row_byte_phase_next = row_byte_phase + 2'd1;
          if (byte_in_pixel == lastbyte) begin
            byte_in_pixel_next = '0;
            column_count_next  = col_inc;
            if (col_inc == width_n) begin
              if (row_byte_phase_next == 2'd0) begin
                end_row = 1'b1;
              end else begin
                phase_next = PH_PAD;
              end
            end
          end else begin
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end
        end

        PH_PAD: begin
          row_byte_phase_next = row_byte_phase + 2'd1;
          if (row_byte_phase_next == 2'd0) begin
            end_row = 1'b1;
          end
        end

        PH_IDLE, PH_DONE, PH_ERROR: ignored = 1'b1;

        default: ignored = 1'b1;
      endcase

      if (end_row) begin
        column_count_next   = '0;
        row_byte_phase_next = '0;
        row_count_next      = row_inc;
        phase_next          = (row_inc == height_mag) ? PH_DONE : PH_PIXELS;
      end

      if (!ignored) begin
        byte_position_next = byte_position_next + 32'd1;
        if (err != ST_OK) begin
          phase_next = PH_ERROR;
        end else if (item.end_of_file && phase_next != PH_DONE) begin
          err        = ST_TRUNCATED;
          phase_next = PH_ERROR;
        end

        res_valid = pix || (err != ST_OK);
        if (pix) begin
          col_wide        = 32'(column_count);
          row_wide        = 32'(row_idx);
          res.pixel_valid = 1'b1;
          res.red         = b;
          res.green       = held_green;
          res.blue        = held_blue;
          res.column      = col_wide[11:0];
          res.row         = row_wide[11:0];
          res.image_done  = last;
        end
        res.status = err;
      end
    end
  end

  a_pad_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> (row_byte_phase != 2'd0))
    else $error("pad phase entered on a 4-byte row boundary");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (column_count < image_width[COL_W-1:0]))
    else $error("column count reached image width while in pixel phase");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS || phase == PH_PAD) |-> (row_count < height_mag))
    else $error("row count beyond image height while decoding rows");

  a_error_parks: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.status != ST_OK) |=> (phase == PH_ERROR))
    else $error("error reported but parser did not park in error phase");

endmodule

// ===== rtl/bmpd_out_reg.sv =====
// ----------------------------------------------------------------------------
// bmpd_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module bmpd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bmpd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output bmpd_pkg::result_t result
);
  import bmpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

// ===== test/tb_bmp_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_bmp_pixel_stream_decoder
// Feeds BMP byte streams (valid, broken, truncated and abandoned files) into
// the decoder with random gaps and back pressure, and compares every pixel
// and status item against an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned HEADER_LEN   = 54;
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

  typedef enum int {
    F_GOOD,
    F_TRUNCATE,
    F_ABANDON,
    F_BAD_SIG,
    F_BAD_COMP,
    F_BAD_BPP,
    F_BAD_WIDTH,
    F_ZERO_HEIGHT,
    F_TOO_WIDE,
    F_TOO_TALL,
    F_LOW_OFFSET,
    F_KIND_COUNT
  } file_kind_e;

  class pixel_scoreboard;
    result_t     results_due[$];
    int unsigned results_predicted;
    int unsigned errors;

    phase_t      phase;
    logic [31:0] pos;
    logic [15:0] sig;
    logic [31:0] offs;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] comp;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [1:0]  byte_in_pix;
    logic [1:0]  row_phase;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;

    function new();
      results_predicted = 0;
      errors = 0;
      clear_file();
      phase = PH_IDLE;
    endfunction

    function void clear_file();
      pos = '0; sig = '0; offs = '0; width = '0; height = '0; bpp = '0; comp = '0;
      col_cnt = '0; row_cnt = '0; byte_in_pix = '0; row_phase = '0;
      held_blue = '0; held_green = '0;
    endfunction

    function logic [31:0] height_mag();
      return height[31] ? -height : height;
    endfunction

    function void finish_row();
      col_cnt = '0;
      row_phase = '0;
      row_cnt = row_cnt + 1;
      if (row_cnt >= height_mag()) phase = PH_DONE;
      else phase = PH_PIXELS;
    endfunction

    // Advance the decoder by one accepted byte and queue the item it produces.
    function void take_byte(logic [7:0] b, logic sof, logic eof);
      result_t     res;
      status_t     err;
      logic [31:0] hm;
      logic [31:0] flip_row;
      logic [1:0]  last_idx;
      res = '0;
      err = ST_OK;
      if (sof) begin
        clear_file();
        phase = PH_HEADER;
      end
      case (phase)
        PH_HEADER: begin
          if (pos == 0) sig[7:0] = b;
          else if (pos == 1) sig[15:8] = b;
          else if (pos >= 10 && pos <= 13) offs[8*(pos-10) +: 8] = b;
          else if (pos >= 18 && pos <= 21) width[8*(pos-18) +: 8] = b;
          else if (pos >= 22 && pos <= 25) height[8*(pos-22) +: 8] = b;
          else if (pos >= 28 && pos <= 29) bpp[8*(pos-28) +: 8] = b;
          else if (pos >= 30 && pos <= 33) comp[8*(pos-30) +: 8] = b;
          if (pos == 13 && sig != BMP_SIGNATURE) begin
            err = ST_BAD_SIG;
          end else if (pos == HEADER_LEN - 1) begin
            hm = height_mag();
            if (comp != 0 || (bpp != 16'd24 && bpp != 16'd32)) err = ST_UNSUPPORTED;
            else if (width == 0 || width[31] || height == 0) err = ST_BAD_SIZE;
            else if (width > DEF_MAX_WIDTH || hm > DEF_MAX_HEIGHT) err = ST_TOO_LARGE;
            else if (offs < HEADER_LEN) err = ST_BAD_OFFSET;
            else if (offs == HEADER_LEN) phase = PH_PIXELS;
            else phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (pos + 1 == offs) phase = PH_PIXELS;
        end
        PH_PIXELS: begin
          last_idx = (bpp == 16'd32) ? 2'd3 : 2'd2;
          case (byte_in_pix)
            2'd0: held_blue = b;
            2'd1: held_green = b;
            2'd2: begin
              hm = height_mag();
              flip_row = hm - 1 - row_cnt;
              res.pixel_valid = 1'b1;
              res.red = b;
              res.green = held_green;
              res.blue = held_blue;
              res.column = col_cnt[11:0];
              res.row = height[31] ? row_cnt[11:0] : flip_row[11:0];
              res.image_done = (col_cnt + 1 == width) && (row_cnt + 1 == hm);
            end
            default: ;
          endcase
          row_phase = row_phase + 2'd1;
          if (byte_in_pix >= last_idx) begin
            byte_in_pix = '0;
            col_cnt = col_cnt + 1;
            if (col_cnt >= width) begin
              if (row_phase == 0) finish_row();
              else phase = PH_PAD;
            end
          end else begin
            byte_in_pix = byte_in_pix + 2'd1;
          end
        end
        PH_PAD: begin
          row_phase = row_phase + 2'd1;
          if (row_phase == 0) finish_row();
        end
        default: return;
      endcase
      pos = pos + 1;
      if (err != ST_OK) begin
        phase = PH_ERROR;
      end else if (eof && phase != PH_DONE) begin
        err = ST_TRUNCATED;
        phase = PH_ERROR;
      end
      if (res.pixel_valid || err != ST_OK) begin
        res.status = err;
        results_due.push_back(res);
        results_predicted++;
      end
    endfunction

    function string describe(result_t r);
      return $sformatf("pv=%0b rgb=%02h/%02h/%02h col=%0d row=%0d done=%0b status=%0d",
                       r.pixel_valid, r.red, r.green, r.blue, r.column, r.row,
                       r.image_done, r.status);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected item: %s", $time, describe(got));
        return;
      end
      want = results_due.pop_front();
      if (got.pixel_valid !== want.pixel_valid || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.column !== want.column || got.row !== want.row ||
          got.image_done !== want.image_done || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                   describe(want), describe(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        start_of_file = 1'b0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pixel_valid;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] row;
  logic        image_done;
  logic [2:0]  status;

  pixel_scoreboard decoder_sb;
  int unsigned     cycle_count = 0;
  int unsigned     small_bytes = 0;
  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  bit              rx_hold = 1'b0;

  bmp_pixel_stream_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_valid   (pixel_valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .column        (column),
    .row           (row),
    .image_done    (image_done),
    .status        (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void put32(ref logic [7:0] img[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) img.push_back(v[8*i +: 8]);
  endfunction

  // Lay out a 54-byte header, then optionally the gap and the rows, then up to three trailing bytes.
  function automatic void build_image(ref logic [7:0] img[$], output int unsigned data_end,
                                      input logic [15:0] sig, input logic [31:0] offs,
                                      input logic [31:0] w, input logic [31:0] h,
                                      input logic [15:0] bpp, input logic [31:0] comp,
                                      input bit with_pixels);
    int unsigned rows;
    int unsigned row_bytes;
    img = {};
    img.push_back(sig[7:0]);
    img.push_back(sig[15:8]);
    put32(img, $urandom);
    put32(img, $urandom);
    put32(img, offs);
    put32(img, $urandom);
    put32(img, w);
    put32(img, h);
    img.push_back(8'($urandom));
    img.push_back(8'($urandom));
    img.push_back(bpp[7:0]);
    img.push_back(bpp[15:8]);
    put32(img, comp);
    repeat (20) img.push_back(8'($urandom));
    if (with_pixels) begin
      rows = h[31] ? -h : h;
      row_bytes = ((w * (bpp / 8)) + 3) & ~32'd3;
      while (img.size() < offs) img.push_back(8'($urandom));
      repeat (rows * row_bytes) img.push_back(8'($urandom));
    end
    data_end = img.size();
    repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    end_of_file   <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decoder_sb.take_byte(b, sof, eof);
  endtask

  // Send the first count bytes; start on the first, end flag on the last if asked.
  task automatic send_file(input logic [7:0] img[$], input int unsigned count,
                           input bit with_eof);
    for (int unsigned i = 0; i < count; i++) begin
      send_byte(img[i], i == 0, with_eof && i == count - 1);
    end
  endtask

  // Drop valid so the last byte is not taken again, then wait for every due item.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoder_sb.results_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_file(input file_kind_e kind);
    logic [7:0]  img[$];
    logic [15:0] sig;
    logic [15:0] bpp;
    logic [31:0] offs;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] comp;
    int unsigned data_end;
    int unsigned count;
    bit          with_eof;
    bit          good_hdr;
    sig = BMP_SIGNATURE;
    bpp = $urandom_range(0, 1) ? 16'd32 : 16'd24;
    w = $urandom_range(1, 5);
    h = $urandom_range(1, 3);
    if ($urandom_range(0, 1)) h = -h;
    offs = $urandom_range(0, 1) ? HEADER_LEN : HEADER_LEN + $urandom_range(1, 9);
    comp = '0;
    good_hdr = 1'b0;
    case (kind)
      F_BAD_SIG: sig = sig ^ 16'($urandom_range(1, 16'hFFFF));
      F_BAD_COMP: begin
        comp = $urandom;
        if (comp == 0) comp = 32'd1;
        if ($urandom_range(0, 1)) w = '0;
      end
      F_BAD_BPP: begin
        case ($urandom_range(0, 2))
          0: bpp = 16'd16;
          1: bpp = 16'hFFFF;
          default: bpp = 16'($urandom);
        endcase
        if (bpp == 16'd24 || bpp == 16'd32) bpp = 16'd8;
        if ($urandom_range(0, 1)) h = '0;
      end
      F_BAD_WIDTH: begin
        w = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
        if ($urandom_range(0, 1)) offs = $urandom_range(0, HEADER_LEN - 1);
      end
      F_ZERO_HEIGHT: h = '0;
      F_TOO_WIDE: begin
        w = $urandom_range(0, 1) ? DEF_MAX_WIDTH + 1
                                 : $urandom_range(DEF_MAX_WIDTH + 1, 32'h7FFF_FFFF);
      end
      F_TOO_TALL: begin
        case ($urandom_range(0, 3))
          0: h = DEF_MAX_HEIGHT + 1;
          1: h = -(DEF_MAX_HEIGHT + 1);
          2: h = 32'h8000_0000;
          default: h = $urandom_range(DEF_MAX_HEIGHT + 1, 32'h7FFF_FFFF);
        endcase
      end
      F_LOW_OFFSET: offs = $urandom_range(0, HEADER_LEN - 1);
      default: good_hdr = 1'b1;
    endcase
    build_image(img, data_end, sig, offs, w, h, bpp, comp, good_hdr);
    count = img.size();
    with_eof = $urandom_range(0, 3) != 0;
    if (kind == F_TRUNCATE) begin
      // mostly cut past the header (gap or pixel area), sometimes inside the header
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, HEADER_LEN)
                                           : $urandom_range(HEADER_LEN + 1, data_end - 1);
      with_eof = 1'b1;
    end else if (kind == F_ABANDON) begin
      count = $urandom_range(1, data_end - 1);
      with_eof = 1'b0;
    end
    tx_calm = $urandom_range(0, 3) == 0;
    send_file(img, count, with_eof);
    small_bytes += count;
  endtask

  // Result side: random stall before each item, one long hold on request.
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        stall = LONG_HOLD;
        rx_hold = 1'b0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.pixel_valid = pixel_valid;
      got.red         = red;
      got.green       = green;
      got.blue        = blue;
      got.column      = column;
      got.row         = row;
      got.image_done  = image_done;
      got.status      = status_t'(status);
      decoder_sb.check_result(got);
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin : stimulus
    logic [7:0]  img[$];
    int unsigned data_end;
    int unsigned pick;
    file_kind_e  kind;
    decoder_sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes before any start of file, one with the end flag: dropped
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // start and end on the same byte: truncated in the header
    send_byte(8'hFF, 1'b1, 1'b1);
    // abandon a header part way, then restart with a swapped signature ending on byte 13
    build_image(img, data_end, BMP_SIGNATURE, HEADER_LEN, 32'd2, 32'd2, 16'd24, '0, 1'b0);
    send_file(img, 6, 1'b0);
    build_image(img, data_end, 16'h424D, HEADER_LEN, 32'd2, 32'd2, 16'd24, '0, 1'b0);
    send_file(img, 14, 1'b1);

    // one file of every kind, then a random mix weighted toward clean files
    for (int k = 0; k < F_KIND_COUNT; k++) random_file(file_kind_e'(k));
    while (small_bytes < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) kind = F_GOOD;
      else if (pick < 13) kind = F_TRUNCATE;
      else if (pick < 15) kind = F_ABANDON;
      else kind = file_kind_e'($urandom_range(F_BAD_SIG, F_LOW_OFFSET));
      random_file(kind);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    // hold the result side long while a clean file streams in back to back
    wait_drained();
    tx_calm = 1'b1;
    rx_hold = 1'b1;
    build_image(img, data_end, BMP_SIGNATURE, HEADER_LEN + 2, 32'd5, 32'd3,
                16'd32, '0, 1'b1);
    send_file(img, img.size(), 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_sb.errors == 0 && decoder_sb.results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
